// ===== src/descending_selection_sort_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the descending selection sort block
// ---------------------------------------------------------------------------
`ifndef DESCENDING_SELECTION_SORT_MACROS_SVH
`define DESCENDING_SELECTION_SORT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define DSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dss: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define DSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dss: next-cycle check failed");

`endif

// ===== src/dss_pkg.sv =====
// ---------------------------------------------------------------------------
// dss_pkg
// Shared types for the descending selection sort block.
// ---------------------------------------------------------------------------
package dss_pkg;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    // Control from the sequencer to the compare unit
    typedef struct packed {
        logic clear;       // start a new pass
        logic elem_valid;  // read data of the store is a candidate this cycle
    } t_scan_ctl;

endpackage

// ===== src/dss_ram.sv =====
// ---------------------------------------------------------------------------
// dss_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module dss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/dss_scan.sv =====
// ---------------------------------------------------------------------------
// dss_scan
// Shared compare unit: keeps the largest untaken entry seen in one pass.
// ---------------------------------------------------------------------------
module dss_scan import dss_pkg::*; #(
    parameter int DATA_WIDTH = 8,
    parameter int IDX_W      = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_scan_ctl             i_ctl,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic                  i_taken,
    input  logic [DATA_WIDTH-1:0] i_data,
    output logic [DATA_WIDTH-1:0] o_best_value,
    output logic [IDX_W-1:0]      o_best_idx
);

    logic                  r_found;
    logic [DATA_WIDTH-1:0] r_best_value;
    logic [IDX_W-1:0]      r_best_idx;
    logic                  w_take;

    // Strict greater-than keeps the lowest index among equal values
    assign w_take = i_ctl.elem_valid && !i_taken && (!r_found || (i_data > r_best_value));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !i_ctl.clear) begin
            r_best_value <= i_data;
            r_best_idx   <= i_idx;
        end
    end

    assign o_best_value = r_best_value;
    assign o_best_idx   = r_best_idx;

endmodule

// ===== src/descending_selection_sort.sv =====
// ---------------------------------------------------------------------------
// descending_selection_sort
// Batch loader and descending selection sorter over a RAM store.
// ---------------------------------------------------------------------------
// Values are loaded one beat per cycle while busy is low. The beat with
// i_batch_end high, or the beat that fills the last of DEPTH entries, closes
// the batch and raises busy. For a batch of n values the block then makes n
// passes over the store through one compare unit; each pass reads one entry
// per cycle from the single read port of the RAM, then waits in S_DRAIN for
// the last read data and presents the result in S_EMIT. Each result is shown
// for one cycle with o_valid high and cannot be held off; o_final_flag marks
// the smallest value, and busy falls in the cycle after it.
// ---------------------------------------------------------------------------
module descending_selection_sort import dss_pkg::*; #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] i_sample_value,
    input  logic                  i_batch_end,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_sorted_value,
    output logic                  o_final_flag
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_rd_valid, n_rd_valid;
    logic [DEPTH-1:0]   r_taken, n_taken;

    logic               w_accept;
    logic [CNT_W-1:0]   w_last;
    logic               w_final;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic [DATA_WIDTH-1:0] w_best_value;
    logic [IDX_W-1:0]   w_best_idx;
    t_scan_ctl          w_scan_ctl;

    assign w_accept = start && (r_state == S_IDLE);
    assign w_last   = r_fill - 1'b1;
    assign w_final  = (r_k == w_last);

    dss_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_fill[IDX_W-1:0]),
        .i_wr_data (i_sample_value),
        .i_rd_en   (r_state == S_SCAN),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_rd_data)
    );

    assign w_scan_ctl.clear      = w_accept || (r_state == S_EMIT);
    assign w_scan_ctl.elem_valid = r_rd_valid;

    dss_scan #(
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_scan_ctl),
        .i_idx        (r_cmp_idx),
        .i_taken      (r_taken[r_cmp_idx]),
        .i_data       (w_rd_data),
        .o_best_value (w_best_value),
        .o_best_idx   (w_best_idx)
    );

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_k        = r_k;
        n_rd_idx   = r_rd_idx;
        n_rd_valid = 1'b0;
        n_taken    = r_taken;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_taken[r_fill[IDX_W-1:0]] = 1'b0;
                    n_fill = r_fill + 1'b1;
                    // a full store closes the batch as well
                    if (i_batch_end || (r_fill == CNT_W'(DEPTH - 1))) begin
                        n_state  = S_SCAN;
                        n_rd_idx = '0;
                        n_k      = '0;
                    end
                end
            end
            S_SCAN: begin
                n_rd_valid = 1'b1;
                if (r_rd_idx == w_last[IDX_W-1:0]) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_taken[w_best_idx] = 1'b1;
                if (w_final) begin
                    n_state = S_IDLE;
                    n_fill  = '0;
                    n_taken = '0;
                end else begin
                    n_k      = r_k + 1'b1;
                    n_rd_idx = '0;
                    n_state  = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_k        <= '0;
            r_rd_idx   <= '0;
            r_rd_valid <= 1'b0;
            r_taken    <= '0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_k        <= n_k;
            r_rd_idx   <= n_rd_idx;
            r_rd_valid <= n_rd_valid;
            r_taken    <= n_taken;
        end
    end

    // follow the read address so the compare sees the index of its data
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_rd_idx;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_EMIT);
    assign o_sorted_value = w_best_value;
    assign o_final_flag   = o_valid && w_final;

endmodule

// ===== src/dss_chk.sv =====
// ---------------------------------------------------------------------------
// dss_chk
// Port-level checks for the descending selection sort block.
// ---------------------------------------------------------------------------
`include "descending_selection_sort_macros.svh"

module dss_chk #(
    parameter int DATA_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  i_batch_end,
    input  logic                  o_valid,
    input  logic [DATA_WIDTH-1:0] o_sorted_value,
    input  logic                  o_final_flag
);

    logic                  r_have_prev;
    logic [DATA_WIDTH-1:0] r_prev;

    // track the previous result beat of the current batch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (o_valid) begin
            r_have_prev <= !o_final_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_valid) begin
            r_prev <= o_sorted_value;
        end
    end

    `DSS_ASSERT_NOW(a_valid_while_busy, i_clk, i_rst_n, o_valid, busy)
    `DSS_ASSERT_NEXT(a_close_raises_busy, i_clk, i_rst_n, start && !busy && i_batch_end, busy)
    `DSS_ASSERT_NEXT(a_final_frees, i_clk, i_rst_n, o_valid && o_final_flag, !busy)
    `DSS_ASSERT_NEXT(a_single_beat, i_clk, i_rst_n, o_valid, !o_valid)
    `DSS_ASSERT_NOW(a_descending, i_clk, i_rst_n, o_valid && r_have_prev, o_sorted_value <= r_prev)

endmodule

bind descending_selection_sort dss_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_dss_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_batch_end    (i_batch_end),
    .o_valid        (o_valid),
    .o_sorted_value (o_sorted_value),
    .o_final_flag   (o_final_flag)
);
